FILE: hw/rtl/ssb_pkg.sv
// Shared types and constants for the sprite sort and batch block.
package ssb_pkg;

    localparam int TEX_W   = 16;
    localparam int DEPTH_W = 32;
    localparam int SLOT_W  = 6;
    localparam int IDX_W   = 9;

    localparam logic [IDX_W-1:0] QUAD_INDICES = IDX_W'(6);

    // commands
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_END   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // sort_mode codes; any other code sorts by texture
    localparam logic [1:0] MODE_TEX        = 2'd0;
    localparam logic [1:0] MODE_DEPTH_UP   = 2'd1;
    localparam logic [1:0] MODE_DEPTH_DOWN = 2'd2;

    typedef logic [SLOT_W-1:0] t_slot;

    typedef struct packed {
        logic [1:0]                command;
        logic [TEX_W-1:0]          texture_id;
        logic signed [DEPTH_W-1:0] sort_depth;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0] sprite_slot;
        logic [TEX_W-1:0]  texture_id_out;
        logic [IDX_W-1:0]  index_offset;
        logic [IDX_W-1:0]  batch_first_index;
        logic [IDX_W-1:0]  batch_index_count;
        logic              ends_batch;
        logic              last;
        logic              dropped;
    } t_result;

    // one stored sprite key
    typedef struct packed {
        logic [TEX_W-1:0]          texture_id;
        logic signed [DEPTH_W-1:0] sort_depth;
        logic [SLOT_W-1:0]         slot;
    } t_entry;

endpackage

FILE: hw/rtl/ssb_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module ssb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/sprite_sort_and_batch.sv
// Top level of the sprite sort and batch block: command decode, sort sequencer, emitter.
//
// Commands transfer on a rising edge with start high and busy low. An add
// stores one sprite key and never raises busy; a clear empties the store.
// An end on a non-empty store raises busy, sorts the store in place with a
// stable insertion sort, then emits one result per stored sprite in sorted
// order, one per cycle, each marked by o_res_valid for exactly one cycle.
// The receiver cannot stall: results must be taken as they appear. The sort
// runs on one store RAM with one read and one write port and one shared key
// comparator: each key is fetched (S_FETCH, S_HOLD), shifted past every
// stored key that must move behind it (S_CMP), and written into its final
// place (S_CMP, or S_PLACE at position 0). The configuration channel is
// ready only while busy is low; write sort_mode between commands. Adds
// beyond SPRITE_CAPACITY are dropped and flagged in the dropped bit of every
// result until the next clear.
module sprite_sort_and_batch #(
    parameter int SPRITE_CAPACITY = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  ssb_pkg::t_in_item i_cmd,
    output logic             o_res_valid,
    output ssb_pkg::t_result o_res,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_data
);
    import ssb_pkg::*;

    localparam int AW = $clog2(SPRITE_CAPACITY);
    localparam int CW = $clog2(SPRITE_CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(SPRITE_CAPACITY);
    localparam int EW = $bits(t_entry);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FETCH = 8'b0000_0010,
        S_HOLD  = 8'b0000_0100,
        S_CMP   = 8'b0000_1000,
        S_PLACE = 8'b0001_0000,
        S_EMIT0 = 8'b0010_0000,
        S_EMIT1 = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic              r_dropped, n_dropped;
    logic [1:0]        r_mode, n_mode;
    logic [CW-1:0]     r_i, n_i;        // next key to insert
    logic [AW-1:0]     r_j, n_j;        // hole position of the key in flight
    t_entry            r_key, n_key;    // key in flight
    t_entry            r_cur, n_cur;    // entry waiting to be emitted
    logic [AW-1:0]     r_ei, n_ei;      // sorted position of r_cur
    logic [IDX_W-1:0]  r_offset, n_offset;
    logic [IDX_W-1:0]  r_bfirst, n_bfirst;
    logic [IDX_W-1:0]  r_bcount, n_bcount;
    logic              r_new, n_new;    // r_cur opens a new batch
    logic              r_res_valid, n_res_valid;
    t_result           r_res, n_res;

    logic              w_we, w_re;
    logic [AW-1:0]     w_waddr, w_raddr;
    t_entry            w_wdata, w_rd;
    logic [EW-1:0]     w_rdata;
    logic              w_move, w_last, w_ends;
    logic              w_take;

    ssb_ram #(
        .WIDTH (EW),
        .DEPTH (SPRITE_CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd        = t_entry'(w_rdata);
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign w_take      = start && (r_state == S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // Shared comparator: stored key read from RAM must move behind the key in flight.
    always_comb begin
        case (r_mode)
            MODE_DEPTH_UP:   w_move = $signed(w_rd.sort_depth) > $signed(r_key.sort_depth);
            MODE_DEPTH_DOWN: w_move = $signed(r_key.sort_depth) > $signed(w_rd.sort_depth);
            default:         w_move = w_rd.texture_id > r_key.texture_id;
        endcase
    end

    // Emitter: RAM data holds the entry after r_cur while emitting.
    assign w_last = ((CW'(r_ei) + CW'(1)) == r_count);
    assign w_ends = w_last || (w_rd.texture_id != r_cur.texture_id);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_dropped   = r_dropped;
        n_mode      = r_mode;
        n_i         = r_i;
        n_j         = r_j;
        n_key       = r_key;
        n_cur       = r_cur;
        n_ei        = r_ei;
        n_offset    = r_offset;
        n_bfirst    = r_bfirst;
        n_bcount    = r_bcount;
        n_new       = r_new;
        n_res_valid = 1'b0;
        n_res       = r_res;
        w_we        = 1'b0;
        w_waddr     = r_j;
        w_wdata     = r_key;
        w_re        = 1'b0;
        w_raddr     = r_j;

        case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    n_mode = i_cfg_data;
                end
                if (w_take) begin
                    case (i_cmd.command)
                        CMD_ADD: begin
                            if (r_count < CAP_C) begin
                                // append at the fill position; slot is the arrival order
                                w_we               = 1'b1;
                                w_waddr            = r_count[AW-1:0];
                                w_wdata.texture_id = i_cmd.texture_id;
                                w_wdata.sort_depth = i_cmd.sort_depth;
                                w_wdata.slot       = t_slot'(r_count);
                                n_count            = r_count + CW'(1);
                            end else begin
                                n_dropped = 1'b1;
                            end
                        end
                        CMD_END: begin
                            if (r_count != '0) begin
                                n_i     = CW'(1);
                                n_state = S_FETCH;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count   = '0;
                            n_dropped = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FETCH: begin
                if (r_i == r_count) begin
                    n_state = S_EMIT0;
                end else begin
                    // read key i; its hole starts at i
                    w_re    = 1'b1;
                    w_raddr = r_i[AW-1:0];
                    n_j     = r_i[AW-1:0];
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                n_key   = w_rd;
                w_re    = 1'b1;
                w_raddr = r_j - AW'(1);
                n_state = S_CMP;
            end
            S_CMP: begin
                if (w_move) begin
                    // shift the stored key up into the hole, look one further down
                    w_we    = 1'b1;
                    w_waddr = r_j;
                    w_wdata = w_rd;
                    n_j     = r_j - AW'(1);
                    if (r_j == AW'(1)) begin
                        n_state = S_PLACE;
                    end else begin
                        w_re    = 1'b1;
                        w_raddr = r_j - AW'(2);
                    end
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_j;
                    w_wdata = r_key;
                    n_i     = r_i + CW'(1);
                    n_state = S_FETCH;
                end
            end
            S_PLACE: begin
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = r_key;
                n_i     = r_i + CW'(1);
                n_state = S_FETCH;
            end
            S_EMIT0: begin
                w_re     = 1'b1;
                w_raddr  = '0;
                n_ei     = '0;
                n_offset = '0;
                n_new    = 1'b1;
                n_state  = S_EMIT1;
            end
            S_EMIT1: begin
                n_cur   = w_rd;
                w_re    = 1'b1;
                w_raddr = AW'(1);
                n_state = S_EMIT;
            end
            S_EMIT: begin
                n_res_valid             = 1'b1;
                n_res.sprite_slot       = r_cur.slot;
                n_res.texture_id_out    = r_cur.texture_id;
                n_res.index_offset      = r_offset;
                n_res.batch_first_index = r_new ? r_offset : r_bfirst;
                n_res.batch_index_count = r_new ? QUAD_INDICES : (r_bcount + QUAD_INDICES);
                n_res.ends_batch        = w_ends;
                n_res.last              = w_last;
                n_res.dropped           = r_dropped;
                n_bfirst                = n_res.batch_first_index;
                n_bcount                = n_res.batch_index_count;
                n_new                   = w_ends;
                n_offset                = r_offset + QUAD_INDICES;
                n_cur                   = w_rd;
                n_ei                    = r_ei + AW'(1);
                // prefetch two ahead; data past the end is never used
                w_re                    = 1'b1;
                w_raddr                 = r_ei + AW'(2);
                if (w_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_mode      <= MODE_TEX;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dropped   <= n_dropped;
            r_mode      <= n_mode;
            r_res_valid <= n_res_valid;
        end
    end

    // hold payload and loop registers without reset
    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_j      <= n_j;
        r_key    <= n_key;
        r_cur    <= n_cur;
        r_ei     <= n_ei;
        r_offset <= n_offset;
        r_bfirst <= n_bfirst;
        r_bcount <= n_bcount;
        r_new    <= n_new;
        r_res    <= n_res;
    end
endmodule

FILE: sim/tb_sprite_sort_and_batch.sv
// Self-checking testbench for sprite_sort_and_batch: directed and random command streams.
module tb_sprite_sort_and_batch;
    timeunit 1ns;
    timeprecision 1ps;

    import ssb_pkg::*;

    localparam int CAPACITY     = 64;
    // Cycles to let pass after the last result before the next phase starts.
    localparam int SETTLE       = 8;
    // Longest stretch with no transfer at all. Worst correct case is a full-store
    // sort under a long sender gap. Allow a wide margin.
    localparam int QUIET_LIMIT  = 20000;
    localparam int RANDOM_ITEMS = 140;

    // The command code the block ignores, and the mode code that sorts like MODE_TEX.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // Predicts the sorted, batched result stream and checks what the block emits.
    class sorted_batch_tracker;
        logic [TEX_W-1:0]          tex_keys   [CAPACITY];
        logic signed [DEPTH_W-1:0] depth_keys [CAPACITY];
        logic [SLOT_W-1:0]         slots      [CAPACITY];
        int                        held;
        bit                        overflow;
        logic [1:0]                mode;
        t_result                   due_results [$];
        int                        mismatches;
        int                        checked;

        function new();
            held       = 0;
            overflow   = 1'b0;
            mode       = MODE_TEX;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void report(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, what);
        endfunction

        // Apply one accepted command; an end with entries queues its results.
        function void note_command(t_in_item item);
            logic [TEX_W-1:0]          kt;
            logic signed [DEPTH_W-1:0] kd;
            logic [SLOT_W-1:0]         ks;
            bit                        move;
            int                        j;
            int                        first;
            int                        count;
            t_result                   r;
            case (item.command)
                CMD_ADD: begin
                    if (held < CAPACITY) begin
                        tex_keys[held]   = item.texture_id;
                        depth_keys[held] = item.sort_depth;
                        slots[held]      = SLOT_W'(held);
                        held++;
                    end else begin
                        overflow = 1'b1;
                    end
                end
                CMD_CLEAR: begin
                    held     = 0;
                    overflow = 1'b0;
                end
                CMD_END: begin
                    // Stable insertion sort in place; the store keeps the new order.
                    for (int i = 1; i < held; i++) begin
                        kt = tex_keys[i];
                        kd = depth_keys[i];
                        ks = slots[i];
                        j  = i;
                        while (j > 0) begin
                            case (mode)
                                MODE_DEPTH_UP:   move = depth_keys[j-1] > kd;
                                MODE_DEPTH_DOWN: move = kd > depth_keys[j-1];
                                default:         move = tex_keys[j-1] > kt;
                            endcase
                            if (!move) break;
                            tex_keys[j]   = tex_keys[j-1];
                            depth_keys[j] = depth_keys[j-1];
                            slots[j]      = slots[j-1];
                            j--;
                        end
                        tex_keys[j]   = kt;
                        depth_keys[j] = kd;
                        slots[j]      = ks;
                    end
                    // Walk the sorted store; a batch runs while the texture holds.
                    for (int i = 0; i < held; i++) begin
                        if (i == 0 || tex_keys[i] != tex_keys[i-1]) begin
                            first = i * int'(QUAD_INDICES);
                            count = int'(QUAD_INDICES);
                        end else begin
                            count += int'(QUAD_INDICES);
                        end
                        r.sprite_slot       = slots[i];
                        r.texture_id_out    = tex_keys[i];
                        r.index_offset      = IDX_W'(i * int'(QUAD_INDICES));
                        r.batch_first_index = IDX_W'(first);
                        r.batch_index_count = IDX_W'(count);
                        r.last              = (i == held - 1);
                        r.ends_batch        = r.last ? 1'b1 : (tex_keys[i+1] != tex_keys[i]);
                        r.dropped           = overflow;
                        due_results.push_back(r);
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare(string field, logic [31:0] got, logic [31:0] want);
            if (got !== want) begin
                report($sformatf("result %0d %s: got %0h, want %0h", checked, field, got, want));
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                report($sformatf("result for slot %0d with nothing pending", got.sprite_slot));
                return;
            end
            want = due_results.pop_front();
            compare("sprite_slot", 32'(got.sprite_slot), 32'(want.sprite_slot));
            compare("texture_id_out", 32'(got.texture_id_out), 32'(want.texture_id_out));
            compare("index_offset", 32'(got.index_offset), 32'(want.index_offset));
            compare("batch_first_index", 32'(got.batch_first_index),
                    32'(want.batch_first_index));
            compare("batch_index_count", 32'(got.batch_index_count),
                    32'(want.batch_index_count));
            compare("ends_batch", 32'(got.ends_batch), 32'(want.ends_batch));
            compare("last", 32'(got.last), 32'(want.last));
            compare("dropped", 32'(got.dropped), 32'(want.dropped));
            checked++;
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_in_item   i_cmd;
    logic       o_res_valid;
    t_result    o_res;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_data;

    sorted_batch_tracker tracker;
    int idle_pct     = 0;
    int quiet_cycles = 0;
    int items_sent   = 0;

    sprite_sort_and_batch #(
        .SPRITE_CAPACITY(CAPACITY)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Sample every handshake at the rising edge, before any update of that edge
    // lands: commands feed the predictor, register writes change its mode,
    // results are checked against the oldest pending one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if (start && !busy) tracker.note_command(i_cmd);
            if (i_cfg_valid && o_cfg_ready) tracker.mode = i_cfg_data;
            if (o_res_valid) tracker.check_result(o_res);
            if ((start && !busy) || (i_cfg_valid && o_cfg_ready) || o_res_valid) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Watchdog: end the run once nothing has transferred for too long.
    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    // Present one command and hold it until the block takes it. Leave start high
    // on return so that a back-to-back command follows without start dropping in between.
    task automatic send(logic [1:0] cmd, logic [TEX_W-1:0] tex, logic [DEPTH_W-1:0] depth);
        t_in_item item;
        item.command    = cmd;
        item.texture_id = tex;
        item.sort_depth = depth;
        // Idle the sender at random; the gap may fall while the block is busy.
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= item;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (cmd != CMD_UNUSED) items_sent++;
    endtask

    // Hold off the sender until every pending result has come and the block is idle.
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.due_results.size() != 0 || busy) @(posedge i_clk);
        // Leave a few quiet cycles before the next phase.
        repeat (SETTLE) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Write sort_mode while the block is idle.
    task automatic set_sort_mode(logic [1:0] mode);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int                        frame;
        int                        n_adds;
        logic [TEX_W-1:0]          tex_base;
        logic [TEX_W-1:0]          tex;
        logic signed [DEPTH_W-1:0] depth;

        tracker = new();
        start       <= 1'b0;
        i_cmd       <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, light sender idling.
        idle_pct = 12;
        // End on an empty store: no results. Then an unused command: ignored.
        send(CMD_END, 16'h0000, 32'h0000_0000);
        send(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
        // Field extremes, repeated textures for batches, a tied depth for stability.
        send(CMD_ADD, 16'h0005, 32'h0000_0000);
        send(CMD_ADD, 16'hFFFF, 32'h7FFF_FFFF);
        send(CMD_ADD, 16'h0000, 32'h8000_0000);
        send(CMD_ADD, 16'h0005, 32'hFFFF_FFFF);
        send(CMD_ADD, 16'hFFFF, 32'h0001_0000);
        send(CMD_ADD, 16'h0005, 32'h8000_0000);
        send(CMD_ADD, 16'h0000, 32'h7FFF_FFFF);
        send(CMD_ADD, 16'h0003, 32'h0000_0000);
        // Sort in the reset mode, then sort the already sorted store again.
        send(CMD_END, 16'h0000, 32'h0000_0000);
        send(CMD_END, 16'hFFFF, 32'hFFFF_FFFF);
        set_sort_mode(MODE_DEPTH_UP);
        send(CMD_END, 16'h0000, 32'h0000_0000);
        set_sort_mode(MODE_DEPTH_DOWN);
        send(CMD_END, 16'h0000, 32'h0000_0000);
        set_sort_mode(MODE_SPARE);
        send(CMD_END, 16'h0000, 32'h0000_0000);
        set_sort_mode(MODE_TEX);
        // Append behind the sorted contents, then sort again.
        send(CMD_ADD, 16'h0004, 32'h0000_0000);
        send(CMD_END, 16'h0000, 32'h0000_0000);
        // Clear, then an end that finds the store empty.
        send(CMD_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
        send(CMD_END, 16'h0000, 32'h0000_0000);

        // Random part: frames of clear, adds, end, with noise mixed in.
        items_sent = 0;
        frame      = 0;
        while (items_sent < RANDOM_ITEMS) begin
            // Rotate the sender's idling so every stretch of work sees gaps and none.
            case (frame % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 74;
                default: idle_pct = 12;
            endcase
            if ($urandom_range(2) == 0) set_sort_mode(2'($urandom_range(3)));
            // Mostly start clean; sometimes append to what the store holds.
            if ($urandom_range(5) != 0) send(CMD_CLEAR, 16'($urandom), 32'($urandom));
            // The first frame overfills the store so that adds get dropped.
            if (frame == 0 || $urandom_range(15) == 0) begin
                n_adds = $urandom_range(CAPACITY + 6, CAPACITY + 1);
            end else begin
                n_adds = $urandom_range(12);
            end
            // Draw textures near a base so batches form; depths often tie.
            tex_base = 16'($urandom);
            for (int k = 0; k < n_adds; k++) begin
                if ($urandom_range(3) != 0) begin
                    tex = tex_base + 16'($urandom_range(3));
                end else begin
                    tex = 16'($urandom);
                end
                if ($urandom_range(1) == 0) begin
                    depth = $urandom;
                end else begin
                    depth = 32'((int'($urandom_range(6)) - 3) * 65536);
                end
                if ($urandom_range(15) == 0) send(CMD_UNUSED, 16'($urandom), 32'($urandom));
                if ($urandom_range(23) == 0) send(CMD_END, 16'($urandom), 32'($urandom));
                send(CMD_ADD, tex, depth);
            end
            send(CMD_END, 16'($urandom), 32'($urandom));
            if ($urandom_range(3) == 0) send(CMD_END, 16'($urandom), 32'($urandom));
            if ($urandom_range(2) == 0) settle();
            frame++;
        end

        settle();
        if (tracker.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
